// ===== sv/sat_pkg.sv =====
// sat_pkg: shared types and constants for the sorted alarm table
// holds table depth, payload structs, kind/mode codes and cell control types
// no dependencies
`default_nettype none

package sat_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = 4;
  localparam int TIME_W = 32;
  localparam int OWN_W  = 22;

  typedef enum logic [1:0] {
    MODE_SCHEDULE = 2'd0,
    MODE_CANCEL   = 2'd1,
    MODE_EXPIRE   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_PAST    = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_REMOVED = 3'd3,
    KIND_LISTED  = 3'd4,
    KIND_BADIDX  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_LIST
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] due_time;
    logic [OWN_W-1:0]  alarm_owner;
    logic [SLOT_W-1:0] slot_index;
    logic [TIME_W-1:0] now_seconds;
  } sat_req_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] entry_slot;
    logic [TIME_W-1:0] entry_time;
    logic [OWN_W-1:0]  entry_owner;
    logic              last;
  } sat_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] etime;
    logic [OWN_W-1:0]  owner;
  } sat_entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] new_time;
    logic [OWN_W-1:0]  new_owner;
  } sat_cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sorted_alarm_table.sv =====
// Sorted alarm table: DEPTH slots kept in ascending due-time order in a chain of
// cells, free slots at the end. Schedule and a bad cancel give one item. Cancel
// gives the removed entry and then, like expire-and-list, walks the expired and
// then the remaining entries: the expiry walk drops one entry a cycle off the
// head of the chain and the list walk reads one slot a cycle, both paced by the
// single output register. A new request is taken only when the sequencer is
// idle. No clearing pass is needed after reset.
// depends on sat_pkg, sat_cell
`default_nettype none

module sorted_alarm_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  sat_pkg::sat_req_t req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output sat_pkg::sat_rsp_t rsp
);
  import sat_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  ecnt, ecnt_next;
  logic [IDX_W-1:0]  lcnt, lcnt_next;
  logic [TIME_W-1:0] now_q, now_next;
  logic [IDX_W-1:0]  rm_from;
  cell_op_t          cell_op;
  logic              emit;
  sat_rsp_t          rsp_next;
  logic              load_ok;

  sat_entry_t        cell_q [DEPTH];
  logic [DEPTH-1:0]  keep;
  logic [DEPTH-1:0]  left_keep;
  logic [DEPTH-1:0]  vld;
  logic [IDX_W-1:0]  ins_slot;
  logic [IDX_W-1:0]  idx_ext;
  logic [IDX_W-1:0]  rd_addr;
  sat_entry_t        rd;
  logic              bad_idx;
  logic              head_expired;

  assign load_ok = !rsp_valid || !rsp_stall;
  assign idx_ext = IDX_W'(req.slot_index);
  assign rd_addr = (state == ST_IDLE) ? idx_ext : lcnt;
  assign rd      = cell_q[rd_addr];
  assign bad_idx = (32'(req.slot_index) >= 32'(DEPTH)) || !vld[idx_ext];
  assign head_expired = cell_q[0].valid && (cell_q[0].etime < now_q);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sat_cell_ctl_t ctl;
    sat_entry_t    left_e;
    sat_entry_t    right_e;

    assign ctl.op = (cell_op == CELL_REMOVE && IDX_W'(i) < rm_from) ? CELL_HOLD : cell_op;
    assign ctl.new_time  = req.due_time;
    assign ctl.new_owner = req.alarm_owner;
    if (i == 0) begin : g_first
      assign left_e       = '0;
      assign left_keep[i] = 1'b1;
    end else begin : g_mid
      assign left_e       = cell_q[i-1];
      assign left_keep[i] = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_nlast
      assign right_e = cell_q[i+1];
    end

    sat_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (left_e),
      .left_keep (left_keep[i]),
      .right     (right_e),
      .q         (cell_q[i]),
      .keep      (keep[i])
    );

    assign vld[i] = cell_q[i].valid;
  end

  // the insert point is the one cell whose left neighbor stays and which does not
  always_comb begin
    ins_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (left_keep[i] && !keep[i]) begin
        ins_slot = ins_slot | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ecnt_next  = ecnt;
    lcnt_next  = lcnt;
    now_next   = now_q;
    emit       = 1'b0;
    rsp_next   = '{kind: KIND_ADDED, default: '0};
    cell_op    = CELL_HOLD;
    rm_from    = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = !load_ok;
        if (req_valid && load_ok) begin
          unique case (req.mode)
            MODE_SCHEDULE: begin
              emit          = 1'b1;
              rsp_next.last = 1'b1;
              if (req.due_time < req.now_seconds) begin
                rsp_next.kind = KIND_PAST;
              end else if (cnt == CNT_W'(DEPTH)) begin
                rsp_next.kind = KIND_FULL;
              end else begin
                cell_op              = CELL_INSERT;
                cnt_next             = cnt + CNT_W'(1);
                rsp_next.kind        = KIND_ADDED;
                rsp_next.entry_slot  = SLOT_W'(ins_slot);
                rsp_next.entry_time  = req.due_time;
                rsp_next.entry_owner = req.alarm_owner;
              end
            end
            MODE_CANCEL: begin
              emit = 1'b1;
              if (bad_idx) begin
                rsp_next.kind       = KIND_BADIDX;
                rsp_next.entry_slot = req.slot_index;
                rsp_next.last       = 1'b1;
              end else begin
                rsp_next.kind        = KIND_REMOVED;
                rsp_next.entry_slot  = req.slot_index;
                rsp_next.entry_time  = rd.etime;
                rsp_next.entry_owner = rd.owner;
                rsp_next.last        = (cnt == CNT_W'(1));
                cell_op    = CELL_REMOVE;
                rm_from    = idx_ext;
                cnt_next   = cnt - CNT_W'(1);
                now_next   = req.now_seconds;
                ecnt_next  = '0;
                state_next = ST_EXPIRE;
              end
            end
            MODE_EXPIRE: begin
              now_next   = req.now_seconds;
              ecnt_next  = '0;
              state_next = ST_EXPIRE;
            end
            default: ;
          endcase
        end
      end
      ST_EXPIRE: begin
        if (head_expired) begin
          if (load_ok) begin
            emit                 = 1'b1;
            rsp_next.kind        = KIND_REMOVED;
            rsp_next.entry_slot  = SLOT_W'(ecnt);
            rsp_next.entry_time  = cell_q[0].etime;
            rsp_next.entry_owner = cell_q[0].owner;
            rsp_next.last        = (cnt == CNT_W'(1));
            cell_op   = CELL_REMOVE;
            cnt_next  = cnt - CNT_W'(1);
            ecnt_next = ecnt + IDX_W'(1);
          end
        end else begin
          lcnt_next  = '0;
          state_next = (cnt == '0) ? ST_IDLE : ST_LIST;
        end
      end
      ST_LIST: begin
        if (load_ok) begin
          emit                 = 1'b1;
          rsp_next.kind        = KIND_LISTED;
          rsp_next.entry_slot  = SLOT_W'(lcnt);
          rsp_next.entry_time  = rd.etime;
          rsp_next.entry_owner = rd.owner;
          rsp_next.last        = (CNT_W'(lcnt) + CNT_W'(1) == cnt);
          lcnt_next            = lcnt + IDX_W'(1);
          if (rsp_next.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ecnt      <= '0;
      lcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ecnt  <= ecnt_next;
      lcnt  <= lcnt_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_q <= now_next;
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  // checks on table order, entry count and request acceptance
  logic [DEPTH-1:0] order_ok;
  always_comb begin
    order_ok = '1;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (vld[i+1] && cell_q[i+1].etime < cell_q[i].etime) begin
        order_ok[i] = 1'b0;
      end
    end
  end

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) == $countones(vld))
    else $error("entry count does not match valid cells");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld & (vld + DEPTH'(1))) == '0)
    else $error("free slot ahead of a used slot");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    order_ok == '1)
    else $error("table lost ascending time order");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> (state == ST_IDLE))
    else $error("request taken while a pass is running");

endmodule

`default_nettype wire

// ===== sv/sat_cell.sv =====
// sat_cell: one slot of the alarm table chain
// holds one entry; inserts in place, shifts right on insert, shifts left on removal
// depends on sat_pkg
`default_nettype none

module sat_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  sat_pkg::sat_cell_ctl_t ctl,
  input  sat_pkg::sat_entry_t    left,
  input  wire logic             left_keep,
  input  sat_pkg::sat_entry_t    right,
  output sat_pkg::sat_entry_t    q,
  output logic                  keep
);
  import sat_pkg::*;

  logic              valid;
  logic [TIME_W-1:0] etime;
  logic [OWN_W-1:0]  owner;
  sat_entry_t        d;

  assign q    = '{valid: valid, etime: etime, owner: owner};
  // entry stays put on insert when it is due no later than the new alarm
  assign keep = valid && (etime <= ctl.new_time);

  always_comb begin
    d = q;
    unique case (ctl.op)
      CELL_HOLD: d = q;
      CELL_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            d = '{valid: 1'b1, etime: ctl.new_time, owner: ctl.new_owner};
          end else begin
            d = left;
          end
        end
      end
      CELL_REMOVE: d = right;
      default: d = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    etime <= d.etime;
    owner <= d.owner;
  end

endmodule

`default_nettype wire
